// File: rtl/core/mdte_pkg.sv
`timescale 1ns / 1ps

package mdte_pkg;

  // Shared divider geometry: 42-bit dividend, 35-bit divisor, 16 quotient bits
  localparam int NUM_W   = 42;
  localparam int DEN_W   = 35;
  localparam int Q_W     = 16;
  localparam int DIV_LAT = Q_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [16:0] HALF_Q16   = 17'd32768;
  localparam logic [16:0] BOX_H_MIN  = 17'd655;
  localparam logic [15:0] DIST_MIN   = 16'd256;
  localparam logic [15:0] DIST_MAX   = 16'd38400;
  localparam logic [17:0] DT_MIN     = 18'd65;
  localparam logic [15:0] SPEED_MIN  = 16'd25;
  localparam logic [15:0] TTC_MAX    = 16'd63936;
  localparam logic [15:0] OFFSET_ONE = 16'd256;
  localparam logic [15:0] POS_MAX    = 16'h7FFF;
  localparam logic [15:0] NEG_MAX    = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HORIZON   = 3'd0,
    CFG_WIDTH_FAR = 3'd1,
    CFG_WIDTH_NEAR = 3'd2,
    CFG_FOCAL     = 3'd3,
    CFG_PED_H     = 3'd4,
    CFG_VEH_H     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] horizon;
    logic [16:0] width_far;
    logic [16:0] width_near;
    logic [15:0] focal;
    logic [11:0] ped_h;
    logic [11:0] veh_h;
  } cfg_t;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] bh;
    logic        ped;
    logic [15:0] prev;
    logic [15:0] age;
    logic [17:0] dt;
    logic [15:0] ego;
  } in_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_op_t;

  // Rides beside the offset and distance dividers
  typedef struct packed {
    logic        in_path;
    logic        row_bad;
    logic        narrow;
    logic        dx_neg;
    logic [8:0]  nar_mag;
    logic [15:0] prev;
    logic        measure;
    logic [17:0] dt;
    logic [15:0] ego;
  } sb1_t;

  // Rides beside the speed divider
  typedef struct packed {
    logic        in_path;
    logic [15:0] offset;
    logic [15:0] distance;
    logic        measure;
    logic        neg;
    logic [15:0] ego;
  } sb2_t;

  // Rides beside the time-to-collision divider
  typedef struct packed {
    logic        in_path;
    logic [15:0] offset;
    logic [15:0] distance;
    logic [15:0] speed;
    logic        closing;
  } sb3_t;

endpackage

// File: rtl/core/mdte_div.sv
`timescale 1ns / 1ps

module mdte_div import mdte_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  div_op_t        op_i,
  output logic [Q_W-1:0] quo_o,
  output logic           ovf_o
);

  logic [DEN_W-1:0] rem_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic [Q_W-1:0]   lo_q  [DIV_LAT];
  logic [Q_W-1:0]   quo_q [DIV_LAT];
  logic             ovf_q [DIV_LAT];

  logic [DEN_W-1:0] hi_d;

  assign hi_d = DEN_W'(op_i.num[NUM_W-1:Q_W]);

  // Quotient needs more than Q_W bits when the upper dividend part reaches the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_d;
      den_q[0] <= op_i.den;
      lo_q[0]  <= op_i.num[Q_W-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= (hi_d >= op_i.den);
    end
  end

  for (genvar s = 1; s < DIV_LAT; s++) begin : g_step
    logic [DEN_W:0]   r_sh;
    logic [DEN_W+1:0] dif;
    logic             take;

    assign r_sh = {rem_q[s-1], lo_q[s-1][Q_W-1]};
    assign dif  = {1'b0, r_sh} - {2'b00, den_q[s-1]};
    assign take = ~dif[DEN_W+1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? dif[DEN_W-1:0] : r_sh[DEN_W-1:0];
        den_q[s] <= den_q[s-1];
        lo_q[s]  <= {lo_q[s-1][Q_W-2:0], 1'b0};
        quo_q[s] <= {quo_q[s-1][Q_W-2:0], take};
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];

endmodule

// File: rtl/core/mdte_front.sv
`timescale 1ns / 1ps

module mdte_front import mdte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  in_t     item_i,
  output logic    valid_o,
  output div_op_t off_op_o,
  output div_op_t dist_op_o,
  output sb1_t    sb_o
);

  typedef struct packed {
    logic               row_bad;
    logic [16:0]        d;
    logic [33:0]        p_far;
    logic signed [35:0] p_dy;
    logic               dx_neg;
    logic [16:0]        adx;
    logic [34:0]        p_x;
    logic [27:0]        p_dist;
    logic [19:0]        den_dist;
    logic [15:0]        prev;
    logic               measure;
    logic [17:0]        dt;
    logic [15:0]        ego;
  } mul_t;

  typedef struct packed {
    logic               row_bad;
    logic [16:0]        d;
    logic [34:0]        w;
    logic               dx_neg;
    logic [16:0]        adx;
    logic [34:0]        p_x;
    logic [27:0]        p_dist;
    logic [19:0]        den_dist;
    logic [15:0]        prev;
    logic               measure;
    logic [17:0]        dt;
    logic [15:0]        ego;
  } sum_t;

  mul_t mul_d, mul_q;
  sum_t sum_d, sum_q;
  logic [2:0] v_q;

  logic [16:0]        h_ext;
  logic [16:0]        dy;
  logic signed [17:0] dw;
  logic signed [17:0] dx;
  logic [16:0]        bh_c;
  logic [11:0]        obj;
  logic signed [36:0] w_full;
  logic [44:0]        w_k;
  logic [33:0]        d_k;
  div_op_t            off_op_d, dist_op_d;
  sb1_t               sb_d;

  // Products
  always_comb begin
    h_ext = {1'b0, cfg_i.horizon};
    dy    = item_i.y - h_ext;
    dw    = $signed({1'b0, cfg_i.width_near}) - $signed({1'b0, cfg_i.width_far});
    dx    = $signed({1'b0, item_i.x}) - $signed({1'b0, HALF_Q16});
    obj   = item_i.ped ? cfg_i.ped_h : cfg_i.veh_h;
    if (item_i.bh < BOX_H_MIN) begin
      bh_c = BOX_H_MIN;
    end else if (item_i.bh > ONE_Q16) begin
      bh_c = ONE_Q16;
    end else begin
      bh_c = item_i.bh;
    end
    mul_d.row_bad  = (item_i.y < h_ext) || (item_i.y > ONE_Q16);
    mul_d.d        = ONE_Q16 - h_ext;
    mul_d.p_far    = cfg_i.width_far * mul_d.d;
    mul_d.p_dy     = $signed({1'b0, dy}) * dw;
    mul_d.dx_neg   = dx[17];
    mul_d.adx      = dx[17] ? 17'(-dx) : dx[16:0];
    mul_d.p_x      = mul_d.adx * {mul_d.d, 1'b0};
    mul_d.p_dist   = cfg_i.focal * obj;
    mul_d.den_dist = ({3'b000, bh_c} << 4) - {3'b000, bh_c};
    mul_d.prev     = item_i.prev;
    mul_d.measure  = (item_i.age > 16'd1) && (item_i.dt > DT_MIN);
    mul_d.dt       = item_i.dt;
    mul_d.ego      = item_i.ego;
  end

  // Corridor width
  always_comb begin
    w_full = $signed({3'b000, mul_q.p_far}) + 37'(mul_q.p_dy);
    sum_d.row_bad  = mul_q.row_bad;
    sum_d.d        = mul_q.d;
    sum_d.w        = w_full[34:0];
    sum_d.dx_neg   = mul_q.dx_neg;
    sum_d.adx      = mul_q.adx;
    sum_d.p_x      = mul_q.p_x;
    sum_d.p_dist   = mul_q.p_dist;
    sum_d.den_dist = mul_q.den_dist;
    sum_d.prev     = mul_q.prev;
    sum_d.measure  = mul_q.measure;
    sum_d.dt       = mul_q.dt;
    sum_d.ego      = mul_q.ego;
  end

  // Path test, narrow test, divider operands
  always_comb begin
    w_k = sum_q.w * 10'd1000;
    d_k = {sum_q.d, 17'd0};
    sb_d.in_path = ~sum_q.row_bad && (sum_q.p_x <= sum_q.w);
    sb_d.row_bad = sum_q.row_bad;
    sb_d.narrow  = ~(w_k > 45'(d_k));
    sb_d.dx_neg  = sum_q.dx_neg;
    sb_d.nar_mag = sum_q.adx[16:8];
    sb_d.prev    = sum_q.prev;
    sb_d.measure = sum_q.measure;
    sb_d.dt      = sum_q.dt;
    sb_d.ego     = sum_q.ego;
    off_op_d.num  = {sum_q.p_x[33:0], 8'd0};
    off_op_d.den  = sum_q.w;
    dist_op_d.num = NUM_W'({sum_q.p_dist, 7'd0});
    dist_op_d.den = DEN_W'(sum_q.den_dist);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q     <= mul_d;
      sum_q     <= sum_d;
      sb_o      <= sb_d;
      off_op_o  <= off_op_d;
      dist_op_o <= dist_op_d;
    end
  end

  assign valid_o = v_q[2];

endmodule

// File: rtl/core/monocular_distance_ttc_estimator_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   box_center_x_i .. ego_speed_i
// output    out        out_valid_o/out_stall_i in_path_o .. collision_time_o
// config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One beat enters per cycle while in_stall_o is low; out_valid_o rises once the
// beat has passed the input register, three front stages, then three chained 17-stage
// restoring dividers (offset and distance side by side, then speed, then time
// to collision) joined by two operand registers, and the output register.
// Reset clears valid bits and loads the default geometry registers.
// A stalled output beat freezes the whole pipe, empty slots included; a stall with no valid output beat is ignored.
module monocular_distance_ttc_estimator_core import mdte_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [16:0]           box_center_x_i,
  input  logic [16:0]           box_bottom_y_i,
  input  logic [16:0]           box_height_i,
  input  logic                  is_pedestrian_i,
  input  logic [15:0]           previous_distance_i,
  input  logic [15:0]           track_age_i,
  input  logic [17:0]           frame_interval_i,
  input  logic signed [15:0]    ego_speed_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  in_path_o,
  output logic signed [15:0]    lateral_offset_o,
  output logic [15:0]           distance_estimate_o,
  output logic signed [15:0]    relative_speed_o,
  output logic [15:0]           collision_time_o
);

  cfg_t cfg_q;
  logic adv;

  in_t  in_q;
  logic in_v_q;

  logic    fr_v;
  div_op_t off_op, dist_op;
  sb1_t    fr_sb;

  logic [Q_W-1:0] off_quo, dist_quo, spd_quo, ttc_quo;
  logic           off_ovf, dist_ovf, spd_ovf, ttc_ovf;

  sb1_t sb1_q [DIV_LAT];
  sb2_t sb2_q [DIV_LAT];
  sb3_t sb3_q [DIV_LAT];
  logic [DIV_LAT-1:0] v1_q, v2_q, v3_q;

  logic    d_v_q, e_v_q;
  sb2_t    d_sb_d, d_sb_q;
  div_op_t spd_op_d, spd_op_q;
  sb3_t    e_sb_d, e_sb_q;
  div_op_t ttc_op_d, ttc_op_q;

  logic               out_v_q;
  logic               in_path_q;
  logic [15:0]        offset_q, dist_q, speed_q, ttc_q, ttc_d;
  logic [15:0]        dist_c;
  logic signed [16:0] diff;
  logic [15:0]        spd_val;
  sb1_t               s1;
  sb2_t               s2;

  assign adv        = ~out_v_q | ~out_stall_i;
  assign in_stall_o = ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.horizon    <= 16'd32768;
      cfg_q.width_far  <= 17'd6554;
      cfg_q.width_near <= 17'd52429;
      cfg_q.focal      <= 16'd12800;
      cfg_q.ped_h      <= 12'd435;
      cfg_q.veh_h      <= 12'd384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HORIZON:    cfg_q.horizon    <= cfg_wdata_i[15:0];
        CFG_WIDTH_FAR:  cfg_q.width_far  <= cfg_wdata_i;
        CFG_WIDTH_NEAR: cfg_q.width_near <= cfg_wdata_i;
        CFG_FOCAL:      cfg_q.focal      <= cfg_wdata_i[15:0];
        CFG_PED_H:      cfg_q.ped_h      <= cfg_wdata_i[11:0];
        CFG_VEH_H:      cfg_q.veh_h      <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.x    <= box_center_x_i;
      in_q.y    <= box_bottom_y_i;
      in_q.bh   <= box_height_i;
      in_q.ped  <= is_pedestrian_i;
      in_q.prev <= previous_distance_i;
      in_q.age  <= track_age_i;
      in_q.dt   <= frame_interval_i;
      in_q.ego  <= ego_speed_i;
    end
  end

  mdte_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .cfg_i     (cfg_q),
    .valid_i   (in_v_q),
    .item_i    (in_q),
    .valid_o   (fr_v),
    .off_op_o  (off_op),
    .dist_op_o (dist_op),
    .sb_o      (fr_sb)
  );

  mdte_div u_div_off (
    .clk_i (clk_i), .en_i (adv), .op_i (off_op), .quo_o (off_quo), .ovf_o (off_ovf)
  );

  mdte_div u_div_dist (
    .clk_i (clk_i), .en_i (adv), .op_i (dist_op), .quo_o (dist_quo), .ovf_o (dist_ovf)
  );

  mdte_div u_div_spd (
    .clk_i (clk_i), .en_i (adv), .op_i (spd_op_q), .quo_o (spd_quo), .ovf_o (spd_ovf)
  );

  mdte_div u_div_ttc (
    .clk_i (clk_i), .en_i (adv), .op_i (ttc_op_q), .quo_o (ttc_quo), .ovf_o (ttc_ovf)
  );

  // Sideband lines that track the divider stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb1_q[0] <= fr_sb;
      sb2_q[0] <= d_sb_q;
      sb3_q[0] <= e_sb_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb1_q[i] <= sb1_q[i-1];
        sb2_q[i] <= sb2_q[i-1];
        sb3_q[i] <= sb3_q[i-1];
      end
    end
  end

  // Offset and distance results, speed operands
  always_comb begin
    s1 = sb1_q[DIV_LAT-1];
    d_sb_d.in_path = s1.in_path;
    if (s1.row_bad) begin
      d_sb_d.offset = OFFSET_ONE;
    end else if (s1.narrow) begin
      d_sb_d.offset = s1.dx_neg ? 16'(-{7'd0, s1.nar_mag}) : {7'd0, s1.nar_mag};
    end else if (s1.dx_neg) begin
      d_sb_d.offset = (off_ovf || off_quo > NEG_MAX) ? NEG_MAX : 16'(-off_quo);
    end else begin
      d_sb_d.offset = (off_ovf || off_quo > POS_MAX) ? POS_MAX : off_quo;
    end
    if (dist_ovf || dist_quo > DIST_MAX) begin
      dist_c = DIST_MAX;
    end else if (dist_quo < DIST_MIN) begin
      dist_c = DIST_MIN;
    end else begin
      dist_c = dist_quo;
    end
    diff = $signed({1'b0, s1.prev}) - $signed({1'b0, dist_c});
    d_sb_d.distance = dist_c;
    d_sb_d.measure  = s1.measure;
    d_sb_d.neg      = diff[16];
    d_sb_d.ego      = s1.ego;
    spd_op_d.num    = NUM_W'({(diff[16] ? 16'(-diff) : diff[15:0]), 16'd0});
    spd_op_d.den    = DEN_W'(s1.dt);
  end

  // Speed result, time operands
  always_comb begin
    s2 = sb2_q[DIV_LAT-1];
    if (s2.neg) begin
      spd_val = (spd_ovf || spd_quo > NEG_MAX) ? NEG_MAX : 16'(-spd_quo);
    end else begin
      spd_val = (spd_ovf || spd_quo > POS_MAX) ? POS_MAX : spd_quo;
    end
    e_sb_d.in_path  = s2.in_path;
    e_sb_d.offset   = s2.offset;
    e_sb_d.distance = s2.distance;
    e_sb_d.speed    = s2.measure ? spd_val : s2.ego;
    e_sb_d.closing  = $signed(e_sb_d.speed) > $signed(SPEED_MIN);
    ttc_op_d.num    = NUM_W'({s2.distance, 6'd0});
    ttc_op_d.den    = DEN_W'(e_sb_d.speed);
  end

  always_comb begin
    if (!sb3_q[DIV_LAT-1].closing || ttc_ovf || ttc_quo > TTC_MAX) begin
      ttc_d = TTC_MAX;
    end else begin
      ttc_d = ttc_quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_sb_q    <= d_sb_d;
      spd_op_q  <= spd_op_d;
      e_sb_q    <= e_sb_d;
      ttc_op_q  <= ttc_op_d;
      in_path_q <= sb3_q[DIV_LAT-1].in_path;
      offset_q  <= sb3_q[DIV_LAT-1].offset;
      dist_q    <= sb3_q[DIV_LAT-1].distance;
      speed_q   <= sb3_q[DIV_LAT-1].speed;
      ttc_q     <= ttc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      v1_q    <= '0;
      d_v_q   <= 1'b0;
      v2_q    <= '0;
      e_v_q   <= 1'b0;
      v3_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q  <= in_valid_i;
      v1_q    <= {v1_q[DIV_LAT-2:0], fr_v};
      d_v_q   <= v1_q[DIV_LAT-1];
      v2_q    <= {v2_q[DIV_LAT-2:0], d_v_q};
      e_v_q   <= v2_q[DIV_LAT-1];
      v3_q    <= {v3_q[DIV_LAT-2:0], e_v_q};
      out_v_q <= v3_q[DIV_LAT-1];
    end
  end

  assign out_valid_o         = out_v_q;
  assign in_path_o           = in_path_q;
  assign lateral_offset_o    = offset_q;
  assign distance_estimate_o = dist_q;
  assign relative_speed_o    = speed_q;
  assign collision_time_o    = ttc_q;

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (distance_estimate_o >= DIST_MIN) && (distance_estimate_o <= DIST_MAX))
    else $error("distance outside clamp range");

  a_ttc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> collision_time_o <= TTC_MAX)
    else $error("collision time above ceiling");

  a_not_closing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (relative_speed_o <= $signed(SPEED_MIN))) |-> collision_time_o == TTC_MAX)
    else $error("collision time given for non-closing object");

  a_in_path_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_path_o) |->
      (lateral_offset_o <= 16'sd256) && (lateral_offset_o >= -16'sd256))
    else $error("in-path box with offset beyond one half width");

endmodule

// File: verif/mdte_scoreboard.sv
`timescale 1ns / 1ps

module mdte_scoreboard import mdte_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [16:0]           box_center_x_i,
  input  logic [16:0]           box_bottom_y_i,
  input  logic [16:0]           box_height_i,
  input  logic                  is_pedestrian_i,
  input  logic [15:0]           previous_distance_i,
  input  logic [15:0]           track_age_i,
  input  logic [17:0]           frame_interval_i,
  input  logic [15:0]           ego_speed_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  in_path_i,
  input  logic [15:0]           lateral_offset_i,
  input  logic [15:0]           distance_estimate_i,
  input  logic [15:0]           relative_speed_i,
  input  logic [15:0]           collision_time_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic        in_path;
    logic [15:0] offset;
    logic [15:0] distance;
    logic [15:0] speed;
    logic [15:0] ttc;
  } track_res_t;

  cfg_t       geom;
  track_res_t expected_q[$];

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic track_res_t estimate_track(in_t b);
    track_res_t r;
    longint hz, d, w, dx, adx, bh, dist_v, speed, ttc, obj, ego;
    hz = geom.horizon;
    ego = longint'($signed(b.ego));
    r.in_path = 1'b0;
    if (b.y < hz || b.y > ONE_Q16) begin
      r.offset = OFFSET_ONE;
    end else begin
      d = 65536 - hz;
      w = longint'(geom.width_far) * d
        + (longint'(b.y) - hz) * (longint'(geom.width_near) - longint'(geom.width_far));
      dx = longint'(b.x) - 32768;
      adx = dx < 0 ? -dx : dx;
      r.in_path = (adx * 2 * d <= w);
      // narrow corridor: divide by a unit half width instead
      if (1000 * w > 131072 * d) r.offset = 16'(clip16((dx * 2 * d * 256) / w));
      else r.offset = 16'(clip16(dx / 256));
    end
    obj = b.ped ? geom.ped_h : geom.veh_h;
    bh = b.bh;
    if (bh < BOX_H_MIN) bh = BOX_H_MIN;
    if (bh > ONE_Q16) bh = ONE_Q16;
    dist_v = (longint'(geom.focal) * obj * 128) / (15 * bh);
    if (dist_v < DIST_MIN) dist_v = DIST_MIN;
    if (dist_v > DIST_MAX) dist_v = DIST_MAX;
    if (b.age > 1 && b.dt > DT_MIN)
      speed = clip16(((longint'(b.prev) - dist_v) * 65536) / longint'(b.dt));
    else speed = ego;
    if (speed <= longint'(SPEED_MIN)) begin
      ttc = TTC_MAX;
    end else begin
      ttc = (dist_v * 64) / speed;
      if (ttc > TTC_MAX) ttc = TTC_MAX;
    end
    r.distance = 16'(dist_v);
    r.speed = 16'(speed);
    r.ttc = 16'(ttc);
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    track_res_t exp_r, got;
    in_t b;
    if (!rst_ni) begin
      geom <= '{horizon: 16'd32768, width_far: 17'd6554, width_near: 17'd52429,
                focal: 16'd12800, ped_h: 12'd435, veh_h: 12'd384};
      expected_q.delete();
      errors_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HORIZON:    geom.horizon <= cfg_wdata_i[15:0];
          CFG_WIDTH_FAR:  geom.width_far <= cfg_wdata_i;
          CFG_WIDTH_NEAR: geom.width_near <= cfg_wdata_i;
          CFG_FOCAL:      geom.focal <= cfg_wdata_i[15:0];
          CFG_PED_H:      geom.ped_h <= cfg_wdata_i[11:0];
          CFG_VEH_H:      geom.veh_h <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{in_path_i, lateral_offset_i, distance_estimate_i, relative_speed_i,
                collision_time_i};
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("ERROR: unexpected result beat %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10)
              $display("ERROR: beat %0d exp path=%0b off=%0d dist=%0d spd=%0d ttc=%0d got path=%0b off=%0d dist=%0d spd=%0d ttc=%0d",
                       checked_o, exp_r.in_path, $signed(exp_r.offset), exp_r.distance,
                       $signed(exp_r.speed), exp_r.ttc, got.in_path, $signed(got.offset),
                       got.distance, $signed(got.speed), got.ttc);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        b = '{box_center_x_i, box_bottom_y_i, box_height_i, is_pedestrian_i,
              previous_distance_i, track_age_i, frame_interval_i, ego_speed_i};
        expected_q.push_back(estimate_track(b));
      end
    end
  end

endmodule

// File: verif/tb_monocular_distance_ttc_estimator_core.sv
`timescale 1ns / 1ps

module tb_monocular_distance_ttc_estimator_core;
  import mdte_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0, in_stall;
  logic [16:0] bx = '0, by = '0, bh = '0;
  logic ped = 1'b0;
  logic [15:0] prev = '0, age = '0;
  logic [17:0] dt = '0;
  logic signed [15:0] ego = '0;
  logic out_valid, out_stall = 1'b0;
  logic path;
  logic signed [15:0] offset, speed;
  logic [15:0] dist_est, ttc;
  int errors, pending, checked, cycles = 0;
  bit quiet = 0;
  bit draining = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  monocular_distance_ttc_estimator_core dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .box_center_x_i(bx), .box_bottom_y_i(by), .box_height_i(bh), .is_pedestrian_i(ped),
    .previous_distance_i(prev), .track_age_i(age), .frame_interval_i(dt),
    .ego_speed_i(ego), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .in_path_o(path), .lateral_offset_o(offset), .distance_estimate_o(dist_est),
    .relative_speed_o(speed), .collision_time_o(ttc)
  );

  mdte_scoreboard u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .box_center_x_i(bx), .box_bottom_y_i(by), .box_height_i(bh), .is_pedestrian_i(ped),
    .previous_distance_i(prev), .track_age_i(age), .frame_interval_i(dt),
    .ego_speed_i(ego), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .in_path_i(path), .lateral_offset_i(offset), .distance_estimate_i(dist_est),
    .relative_speed_i(speed), .collision_time_i(ttc),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // receiver backpressure in bursts, off once the run goes quiet
  always @(posedge clk) begin
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 5);
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_geometry(logic [15:0] hz, logic [16:0] wf, logic [16:0] wn,
                               logic [15:0] fl, logic [11:0] ph, logic [11:0] vh);
    // drop valid so the last beat is not taken again while draining
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_HORIZON, 17'(hz));
    write_reg(CFG_WIDTH_FAR, wf);
    write_reg(CFG_WIDTH_NEAR, wn);
    write_reg(CFG_FOCAL, 17'(fl));
    write_reg(CFG_PED_H, 17'(ph));
    write_reg(CFG_VEH_H, 17'(vh));
  endtask

  // drive one beat and hold it until accepted
  task automatic send_box(logic [16:0] x, logic [16:0] y, logic [16:0] h, logic p,
                          logic [15:0] pd, logic [15:0] a, logic [17:0] t,
                          logic [15:0] e);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    bx <= x; by <= y; bh <= h; ped <= p;
    prev <= pd; age <= a; dt <= t; ego <= e;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic random_boxes(int n, logic [15:0] hz);
    logic [16:0] x, y, h;
    logic [15:0] a, pd;
    logic [17:0] t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       y = 17'($urandom_range(0, 131071));
        1:       y = 17'($urandom_range(0, 65536));
        default: y = 17'($urandom_range(hz, 65536));
      endcase
      x = $urandom_range(0, 3) == 0 ? 17'($urandom_range(0, 131071))
                                    : 17'($urandom_range(16384, 49152));
      case ($urandom_range(0, 3))
        0:       h = 17'($urandom_range(0, 131071));
        1:       h = 17'($urandom_range(0, 1000));
        default: h = 17'($urandom_range(655, 40000));
      endcase
      a = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom);
      t = $urandom_range(0, 4) == 0 ? 18'($urandom_range(0, 80))
                                    : 18'($urandom_range(0, 262143));
      pd = 16'($urandom_range(0, 38400));
      send_box(x, y, h, 1'($urandom), pd, a, t, 16'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corridor edges, box height clamps, speed fallbacks, not closing
    send_box(17'd32768, 17'd65536, 17'd6554, 1'b0, 16'd0, 16'd0, 18'd0, 16'sd0);
    send_box(17'd0, 17'd65536, 17'd6554, 1'b1, 16'd0, 16'd5, 18'd3277, 16'sd100);
    send_box(17'd131071, 17'd40000, 17'd0, 1'b0, 16'd38400, 16'd2, 18'd66, 16'sd0);
    send_box(17'd32768, 17'd32767, 17'd131071, 1'b1, 16'd256, 16'd2, 18'd65, 16'sd2560);
    send_box(17'd32768, 17'd65537, 17'd655, 1'b0, 16'd1000, 16'd1, 18'd262143, -16'sd32768);
    send_box(17'd32768, 17'd131071, 17'd654, 1'b1, 16'd38400, 16'd65535, 18'd1, 16'sd32767);
    send_box(17'd40000, 17'd32768, 17'd65536, 1'b0, 16'd0, 16'd3, 18'd262143, 16'sd25);
    send_box(17'd20000, 17'd50000, 17'd65537, 1'b1, 16'd65535, 16'd0, 18'd262143, 16'sd26);
    send_box(17'd36045, 17'd60000, 17'd3000, 1'b0, 16'd38400, 16'd9, 18'd66, 16'sd1);
    send_box(17'd32768, 17'd50000, 17'd100000, 1'b1, 16'd0, 16'd9, 18'd66, -16'sd1);
    load_geometry(16'd0, 17'd0, 17'd131071, 16'd65535, 12'd4095, 12'd4095);
    send_box(17'd32768, 17'd0, 17'd655, 1'b0, 16'd0, 16'd2, 18'd66, 16'sd0);
    send_box(17'd32800, 17'd1, 17'd655, 1'b1, 16'd38400, 16'd2, 18'd100, 16'sd0);
    send_box(17'd131071, 17'd10, 17'd1000, 1'b0, 16'd0, 16'd2, 18'd66, 16'sd0);
    send_box(17'd0, 17'd65536, 17'd65536, 1'b1, 16'd38400, 16'd2, 18'd66, 16'sd0);
    random_boxes(350, 16'd0);

    load_geometry(16'd65535, 17'd131071, 17'd0, 16'd0, 12'd0, 12'd0);
    send_box(17'd32768, 17'd65535, 17'd655, 1'b0, 16'd38400, 16'd2, 18'd66, 16'sd0);
    send_box(17'd131071, 17'd65536, 17'd655, 1'b1, 16'd0, 16'd2, 18'd66, 16'sd0);
    random_boxes(300, 16'd65535);

    load_geometry(16'($urandom), 17'($urandom), 17'($urandom), 16'($urandom),
                  12'($urandom), 12'($urandom));
    random_boxes(350, 16'd0);

    load_geometry(16'd30000, 17'd8000, 17'd60000, 16'd12800, 12'd435, 12'd384);
    // unmapped indexes must leave the geometry alone
    write_reg(IDX_UNMAPPED_LO, 17'h1FFFF);
    write_reg(IDX_UNMAPPED_HI, 17'h00000);
    random_boxes(400, 16'd30000);

    load_geometry(16'($urandom_range(0, 60000)), 17'($urandom_range(0, 70000)),
                  17'($urandom_range(0, 131071)), 16'($urandom), 12'($urandom),
                  12'($urandom));
    quiet = 1;
    random_boxes(400, 16'd0);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d result beats over six geometry settings incl. register extremes,",
             checked);
    $display("with corridor, clamp, speed fallback and saturation cases; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mdte_pkg.sv
rtl/core/mdte_div.sv
rtl/core/mdte_front.sv
rtl/core/monocular_distance_ttc_estimator_core.sv
verif/mdte_scoreboard.sv
verif/tb_monocular_distance_ttc_estimator_core.sv
